// ----- hw/rtl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants for the k-way sorted merge unit: default sizes, request
// opcodes, result status codes and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int MAX_LISTS_DEF   = 16;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int OP_W     = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;
  localparam int NUML_W   = 5;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ID  = 2'd3;

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_NUM_LISTS = 2'd0;

  localparam logic [NUML_W-1:0] NUM_LISTS_RST = 5'd16;

endpackage

`default_nettype wire

// ----- hw/rtl/kwm_ram.sv -----
// ----------------------------------------------------------------------------
// kwm_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/k_way_sorted_merge_unit.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// Merges up to K sorted lists kept as linked lists in a shared element store.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one registered result, shown for one cycle with out_valid high, and
// the receiver cannot stall it. A clear, a rejected append (list id at or
// above K, or store full) and an unused opcode are answered from idle. An
// accepted append reads the per-list head table, then writes the value, the
// old tail's link and the table entry. A pop scans the head table one list
// per cycle over the K lists in use; it answers when the scan finds nothing
// or empties a list, and otherwise first follows the popped entry's link and
// reads the new head value. No clearing pass is needed after reset. The
// number of lists in use, K, is written over the APB port at address 0; the
// user must write it only while the unit is idle, which the unit itself does
// not enforce. Zero acts as one and values above MAX_LISTS act as MAX_LISTS.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_unit #(
  parameter int MAX_LISTS   = kwm_pkg::MAX_LISTS_DEF,
  parameter int STORE_DEPTH = kwm_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_BITS  = kwm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [kwm_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [kwm_pkg::ID_W-1:0]      in_list_id,
  input  wire logic signed [VALUE_BITS-1:0]  in_value,
  // Result channel
  output      logic                          out_valid,
  output      logic signed [VALUE_BITS-1:0]  out_value,
  output      logic [kwm_pkg::ID_W-1:0]      out_source_list,
  output      logic [kwm_pkg::STATUS_W-1:0]  out_status,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kwm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int LID_W = $clog2(MAX_LISTS);
  localparam int KW    = $clog2(MAX_LISTS + 1);
  localparam int HT_W  = 2 * PTR_W + VALUE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_APP  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_VAL  = 3'd4;

  // Control state
  logic [2:0]                   state_r, state_nxt;
  logic [PTR_W:0]               fill_r, fill_nxt;
  logic [MAX_LISTS-1:0]         nonempty_r, nonempty_nxt;
  logic [kwm_pkg::NUML_W-1:0]   num_lists_r;
  logic [KW-1:0]                issue_r, issue_nxt;
  logic                         pend_r, pend_nxt;
  logic [KW-1:0]                pend_idx_r, pend_idx_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Payload registers
  logic [LID_W-1:0]             op_id_r, op_id_nxt;
  logic [VALUE_BITS-1:0]        op_val_r, op_val_nxt;
  logic [LID_W-1:0]             best_idx_r, best_idx_nxt;
  logic [PTR_W-1:0]             best_head_r, best_head_nxt;
  logic [PTR_W-1:0]             best_tail_r, best_tail_nxt;
  logic [VALUE_BITS-1:0]        best_val_r, best_val_nxt;
  logic [PTR_W-1:0]             next_ptr_r, next_ptr_nxt;
  logic [VALUE_BITS-1:0]        out_value_r, out_value_nxt;
  logic [kwm_pkg::ID_W-1:0]     out_src_r, out_src_nxt;
  logic [kwm_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  // Memory ports
  logic                         ht_we;
  logic [LID_W-1:0]             ht_waddr, ht_raddr;
  logic [HT_W-1:0]              ht_wdata, ht_rdata;
  logic                         val_we;
  logic [PTR_W-1:0]             val_waddr, val_raddr;
  logic [VALUE_BITS-1:0]        val_rdata;
  logic                         lnk_we;
  logic [PTR_W-1:0]             lnk_waddr, lnk_raddr;
  logic [PTR_W-1:0]             lnk_rdata;

  logic [KW-1:0]                k_use;
  logic                         accept;
  logic [PTR_W-1:0]             rd_head, rd_tail;
  logic [VALUE_BITS-1:0]        rd_hval;
  logic [PTR_W-1:0]             slot;
  logic                         cfg_wr;

  // Head table: one entry per list holding head pointer, tail pointer and the
  // value at the head, so a pop scan needs one read per list.
  kwm_ram #(.WIDTH(HT_W), .DEPTH(MAX_LISTS)) u_head_tab (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .re    (1'b1),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  // Element values, filled in arrival order.
  kwm_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_val_mem (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (op_val_r),
    .re    (1'b1),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Forward links from each element to the next one of its list.
  kwm_ram #(.WIDTH(PTR_W), .DEPTH(STORE_DEPTH)) u_link_mem (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (slot),
    .re    (1'b1),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  assign {rd_head, rd_tail, rd_hval} = ht_rdata;
  assign slot   = fill_r[PTR_W-1:0];
  assign accept = start && !busy;

  // Lists in use, clamped to one through MAX_LISTS.
  always_comb begin
    if (num_lists_r == '0) begin
      k_use = KW'(1);
    end else if (32'(num_lists_r) > MAX_LISTS) begin
      k_use = KW'(MAX_LISTS);
    end else begin
      k_use = KW'(num_lists_r);
    end
  end

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == kwm_pkg::REG_NUM_LISTS) ? 32'(num_lists_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lists_r <= kwm_pkg::NUM_LISTS_RST;
    end else if (cfg_wr && paddr == kwm_pkg::REG_NUM_LISTS) begin
      num_lists_r <= pwdata[kwm_pkg::NUML_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    nonempty_nxt   = nonempty_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    op_id_nxt      = op_id_r;
    op_val_nxt     = op_val_r;
    best_idx_nxt   = best_idx_r;
    best_head_nxt  = best_head_r;
    best_tail_nxt  = best_tail_r;
    best_val_nxt   = best_val_r;
    next_ptr_nxt   = next_ptr_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_src_nxt    = '0;
    out_status_nxt = kwm_pkg::ST_OK;

    ht_we     = 1'b0;
    ht_waddr  = op_id_r;
    ht_wdata  = '0;
    ht_raddr  = in_list_id[LID_W-1:0];
    val_we    = 1'b0;
    val_waddr = slot;
    val_raddr = lnk_rdata;
    lnk_we    = 1'b0;
    lnk_waddr = rd_tail;
    lnk_raddr = best_head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_id_nxt  = in_list_id[LID_W-1:0];
          op_val_nxt = in_value;
          case (in_opcode)
            kwm_pkg::OP_CLEAR: begin
              nonempty_nxt  = '0;
              fill_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            kwm_pkg::OP_APPEND: begin
              if (32'(in_list_id) >= 32'(k_use)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = kwm_pkg::ST_BAD_ID;
              end else if (fill_r == (PTR_W+1)'(STORE_DEPTH)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = kwm_pkg::ST_FULL;
              end else begin
                state_nxt = S_APP;
              end
            end
            kwm_pkg::OP_POP: begin
              issue_nxt = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = kwm_pkg::ST_BAD_ID;
            end
          endcase
        end
      end

      S_APP: begin
        val_we = 1'b1;
        ht_we  = 1'b1;
        if (nonempty_r[op_id_r]) begin
          // Chain the new element behind the current tail.
          lnk_we   = 1'b1;
          ht_wdata = {rd_head, slot, rd_hval};
        end else begin
          ht_wdata = {slot, slot, op_val_r};
        end
        nonempty_nxt[op_id_r] = 1'b1;
        fill_nxt              = fill_r + 1'b1;
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end

      S_SCAN: begin
        // Reads are issued one list per cycle; each comparison happens the
        // cycle after its read, so strict less-than keeps the lowest id on ties.
        ht_raddr = issue_r[LID_W-1:0];
        if (issue_r < k_use) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r;
          issue_nxt    = issue_r + 1'b1;
        end
        if (pend_r) begin
          if (nonempty_r[pend_idx_r[LID_W-1:0]] &&
              (!found_r || $signed(rd_hval) < $signed(best_val_r))) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = pend_idx_r[LID_W-1:0];
            best_head_nxt = rd_head;
            best_tail_nxt = rd_tail;
            best_val_nxt  = rd_hval;
          end
        end else if (issue_r >= k_use) begin
          if (!found_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = kwm_pkg::ST_EMPTY;
            state_nxt      = S_IDLE;
          end else if (best_head_r == best_tail_r) begin
            // Last element of its list: the list just becomes empty.
            nonempty_nxt[best_idx_r] = 1'b0;
            out_valid_nxt = 1'b1;
            out_value_nxt = best_val_r;
            out_src_nxt   = kwm_pkg::ID_W'(best_idx_r);
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_LINK;
          end
        end
      end

      S_LINK: begin
        next_ptr_nxt = lnk_rdata;
        state_nxt    = S_VAL;
      end

      S_VAL: begin
        ht_we         = 1'b1;
        ht_waddr      = best_idx_r;
        ht_wdata      = {next_ptr_r, best_tail_r, val_rdata};
        out_valid_nxt = 1'b1;
        out_value_nxt = best_val_r;
        out_src_nxt   = kwm_pkg::ID_W'(best_idx_r);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      nonempty_r  <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      nonempty_r  <= nonempty_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_id_r      <= op_id_nxt;
    op_val_r     <= op_val_nxt;
    best_idx_r   <= best_idx_nxt;
    best_head_r  <= best_head_nxt;
    best_tail_r  <= best_tail_nxt;
    best_val_r   <= best_val_nxt;
    next_ptr_r   <= next_ptr_nxt;
    out_value_r  <= out_value_nxt;
    out_src_r    <= out_src_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_source_list = out_src_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

// ----- bench/k_way_sorted_merge_unit_tb.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit_tb
// Self-checking bench for the k-way sorted merge unit. Requests are driven on
// the start/busy channel with random gaps, every result is compared against a
// behavioral model of the lists, and the list count is changed over APB
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_unit_tb;

  localparam int OP_W     = kwm_pkg::OP_W;
  localparam int ID_W     = kwm_pkg::ID_W;
  localparam int STATUS_W = kwm_pkg::STATUS_W;
  localparam int NUML_W   = kwm_pkg::NUML_W;
  localparam int PADDR_W  = kwm_pkg::PADDR_W;
  localparam int NLISTS = kwm_pkg::MAX_LISTS_DEF;
  localparam int DEPTH  = kwm_pkg::STORE_DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0]   value;
    logic [ID_W-1:0]      src;
    logic [STATUS_W-1:0]  status;
  } merge_result_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic signed [31:0]   value;
    bit                   typed;   // expected result given in the row
    merge_result_t        res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_opcode = '0;
  logic [ID_W-1:0] in_list_id = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic signed [31:0] out_value;
  logic [ID_W-1:0] out_source_list;
  logic [STATUS_W-1:0] out_status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  k_way_sorted_merge_unit dut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_list_id, .in_value,
    .out_valid, .out_value, .out_source_list, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  // Model state: each list is a queue of its values in order.
  logic signed [31:0] model_lists [NLISTS][$];
  int model_fill;
  logic [NUML_W-1:0] model_num_lists;

  merge_result_t pending_results [$];
  int mismatches, results_seen, pops_ok, fulls, bad_ids, empties;
  longint cycles;

  // Works out the result of one request and updates the list model.
  function automatic merge_result_t merge_predict(logic [OP_W-1:0] op,
                                                  logic [ID_W-1:0] id,
                                                  logic signed [31:0] v);
    merge_result_t r;
    int k, best;
    r = '{value: '0, src: '0, status: kwm_pkg::ST_OK};
    k = (model_num_lists == 0) ? 1 : (model_num_lists > NLISTS ? NLISTS : model_num_lists);
    if (op == kwm_pkg::OP_CLEAR) begin
      foreach (model_lists[i]) model_lists[i].delete();
      model_fill = 0;
    end else if (op == kwm_pkg::OP_APPEND) begin
      if (id >= k) r.status = kwm_pkg::ST_BAD_ID;
      else if (model_fill >= DEPTH) r.status = kwm_pkg::ST_FULL;
      else begin
        model_lists[id].push_back(v);
        model_fill++;
      end
    end else if (op == kwm_pkg::OP_POP) begin
      best = -1;
      for (int i = 0; i < k; i++)
        if (model_lists[i].size() != 0 &&
            (best < 0 || model_lists[i][0] < model_lists[best][0])) best = i;
      if (best < 0) r.status = kwm_pkg::ST_EMPTY;
      else begin
        r.value = model_lists[best].pop_front();
        r.src = best[ID_W-1:0];
      end
    end else begin
      r.status = kwm_pkg::ST_BAD_ID;
    end
    return r;
  endfunction

  // Results are sampled at the rising edge and matched with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      merge_result_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: value %0d src %0d status %0d",
                                       out_value, out_source_list, out_status);
      end else begin
        e = pending_results.pop_front();
        if (e.value !== out_value || e.src !== out_source_list || e.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %0d src %0d status %0d, got %0d %0d %0d",
                     e.value, e.src, e.status, out_value, out_source_list, out_status);
        end
      end
    end
  end

  initial begin
    cycles = 0;
  end

  // Watchdog on the cycle counter.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one request: waits for busy low, holds start for the accepting edge.
  // Start stays high after the accepting edge when the next request follows
  // with no gap; otherwise it drops at the first falling edge of the gap.
  // The prediction is queued at the acceptance edge, before any result.
  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic signed [31:0] v, int gap);
    merge_result_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_list_id <= id;
    in_value <= v;
    do @(posedge clk); while (busy);
    r = merge_predict(op, id, v);
    pending_results.push_back(r);
    case (r.status)
      kwm_pkg::ST_FULL:   fulls++;
      kwm_pkg::ST_EMPTY:  empties++;
      kwm_pkg::ST_BAD_ID: bad_ids++;
      default:            if (op == kwm_pkg::OP_POP) pops_ok++;
    endcase
    @(negedge clk);
  endtask

  // Drops start, then waits until every result is in, plus the longest pop
  // latency, since a result was only expected once per request but the unit
  // may still settle.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (NLISTS + 8) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_num_lists(logic [NUML_W-1:0] k);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= kwm_pkg::REG_NUM_LISTS; pwdata <= 32'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    model_num_lists = k;
  endtask

  task automatic random_gap_send(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic signed [31:0] v);
    int gap;
    // Roughly a third of requests go back to back to cover the no-idle case.
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    send_request(op, id, v, gap);
  endtask

  // Random mix of mostly sorted appends and pops, with unsorted appends, bad ids, clears and unused opcodes.
  task automatic random_merge_phase(int k, int nitems);
    int n;
    logic signed [31:0] run [NLISTS];
    for (int i = 0; i < NLISTS; i++) run[i] = $signed($urandom()) >>> $urandom_range(0, 31);
    n = 0;
    while (n < nitems) begin
      int pick;
      logic [ID_W-1:0] id;
      logic [OP_W-1:0] op;
      logic signed [31:0] v;
      pick = $urandom_range(0, 99);
      id = (pick < 5) ? ID_W'($urandom()) : ID_W'($urandom_range(0, k - 1));
      if (pick < 55) begin
        // Sorted append: list heads keep rising; small steps give ties.
        run[id] = run[id] + $urandom_range(0, 3);
        op = kwm_pkg::OP_APPEND; v = run[id];
      end else if (pick < 60) begin
        op = kwm_pkg::OP_APPEND; v = $urandom();
      end else if (pick < 97) begin
        op = kwm_pkg::OP_POP; v = $urandom();
      end else if (pick < 98) begin
        op = kwm_pkg::OP_CLEAR; v = $urandom();
      end else begin
        op = kwm_pkg::OP_RSVD; v = $urandom();
      end
      random_gap_send(op, id, v);
      n++;
    end
  endtask

  stim_row_t directed [$];

  function automatic stim_row_t row(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                    logic signed [31:0] v, bit typed = 0,
                                    logic signed [31:0] ev = 0,
                                    logic [ID_W-1:0] es = 0,
                                    logic [STATUS_W-1:0] est = kwm_pkg::ST_OK);
    stim_row_t s;
    s.op = op; s.id = id; s.value = v; s.typed = typed;
    s.res = '{value: ev, src: es, status: est};
    return s;
  endfunction

  initial begin
    int gap;
    int k_set [6];
    mismatches = 0; results_seen = 0; pops_ok = 0; fulls = 0; bad_ids = 0; empties = 0;
    model_fill = 0;
    model_num_lists = kwm_pkg::NUM_LISTS_RST;
    k_set = '{2, 16, 5, 1, 9, 16};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: extremes of the value, every opcode, tie on equal heads,
    // pop on empty lists and an unused opcode.
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0, 1, 0, 0, kwm_pkg::ST_EMPTY));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd15, 32'sh7fffffff, 1, 0, 0, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd0, 32'sh80000000, 1, 0, 0, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd3, 5, 1, 0, 0, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd1, 5, 1, 0, 0, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd0, 32'sh7fffffff));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd9, 32'shffffffff, 1, 32'sh80000000, 0,
                           kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0, 1, 5, 1, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0, 1, 0, 0, kwm_pkg::ST_EMPTY));
    directed.push_back(row(kwm_pkg::OP_RSVD, 4'd15, 32'shffffffff, 1, 0, 0,
                           kwm_pkg::ST_BAD_ID));
    directed.push_back(row(kwm_pkg::OP_APPEND, 4'd2, -1));
    directed.push_back(row(kwm_pkg::OP_CLEAR, 4'd15, 32'shffffffff, 1, 0, 0, kwm_pkg::ST_OK));
    directed.push_back(row(kwm_pkg::OP_POP, 4'd0, 0, 1, 0, 0, kwm_pkg::ST_EMPTY));
    foreach (directed[i]) begin
      merge_result_t r;
      gap = $urandom_range(0, 3);
      send_request(directed[i].op, directed[i].id, directed[i].value, gap);
      // A typed row must also agree with the model, or the row is wrong.
      r = pending_results[$];
      if (directed[i].typed && r !== directed[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("Directed row %0d disagrees with prediction", i);
      end
    end
    drain_results();

    // Smallest K: ids above zero are rejected.
    write_num_lists(5'd1);
    send_request(kwm_pkg::OP_APPEND, 4'd1, 7, 0);
    send_request(kwm_pkg::OP_APPEND, 4'd0, 9, 0);
    send_request(kwm_pkg::OP_POP, 4'd0, 0, 0);
    drain_results();
    // Zero acts as one; thirty-one acts as the maximum.
    write_num_lists(5'd0);
    send_request(kwm_pkg::OP_APPEND, 4'd0, 3, 0);
    send_request(kwm_pkg::OP_POP, 4'd0, 0, 0);
    drain_results();
    write_num_lists(5'd31);
    send_request(kwm_pkg::OP_APPEND, 4'd15, -3, 0);
    send_request(kwm_pkg::OP_POP, 4'd0, 0, 0);
    send_request(kwm_pkg::OP_CLEAR, 4'd0, 0, 0);
    drain_results();

    // Store-full phase: fill the whole store, then overflow it.
    write_num_lists(5'd16);
    for (int i = 0; i < DEPTH + 4; i++)
      send_request(kwm_pkg::OP_APPEND, ID_W'($urandom()), $urandom(), 0);
    for (int i = 0; i < 40; i++) send_request(kwm_pkg::OP_POP, 4'd0, 0, 0);
    send_request(kwm_pkg::OP_CLEAR, 4'd0, 0, 0);
    drain_results();

    // Random merges under several list counts, one idle pause per phase.
    foreach (k_set[p]) begin
      write_num_lists(NUML_W'(k_set[p]));
      random_merge_phase(k_set[p], 27);
      drain_results();
    end

    $display("Covered %0d results: %0d ok pops, %0d empty, %0d store full, %0d bad id.",
             results_seen, pops_ok, empties, fulls, bad_ids);
    $display("List counts 0, 1, 2, 5, 9, 16 and 31 were used, with a full store.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, missing results: %0d", mismatches, pending_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
